FILE: rtl/tlgr_pkg.sv
// Shared types, constants and font functions for the text line glyph rasterizer.
// Used by every module of the block; depends on nothing.
package tlgr_pkg;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_CHAR   = 2'd1,
    MODE_END    = 2'd2,
    MODE_SETROW = 2'd3
  } mode_t;

  localparam logic [8:0] WRAP_ABOVE  = 9'd444;
  localparam logic [8:0] WRAP_TO     = 9'd124;
  localparam logic [8:0] ROW_MAX     = 9'd511;
  localparam logic [9:0] COL_START   = 10'd20;
  localparam logic [9:0] COL_LIMIT   = 10'd612;
  localparam logic [9:0] COL_STEP    = 10'd12;
  localparam logic [9:0] LINE_HEIGHT = 10'd22;
  localparam logic [9:0] FILL_X      = 10'd16;
  localparam logic [9:0] FILL_LEN    = 10'd608;
  localparam logic [9:0] GLYPH_LEN   = 10'd10;
  localparam logic [4:0] FILL_END    = 5'd21;
  localparam logic [4:0] GLYPH_END   = 5'd13;

  localparam logic [15:0] BG_RESET   = 16'h0864;
  localparam logic [15:0] TEXT_RESET = 16'hFFFF;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int FONT_GLYPHS = 36;
  localparam logic [5:0] G_DIGIT0 = 6'd26;
  localparam logic [5:0] G_DASH   = 6'd36;
  localparam logic [5:0] G_COLON  = 6'd37;
  localparam logic [5:0] G_DOT    = 6'd38;
  localparam logic [5:0] G_SLASH  = 6'd39;
  localparam logic [5:0] G_NONE   = 6'd40;

  typedef struct packed {
    logic       is_fill;
    logic [8:0] row;
    logic [9:0] x;
    logic [5:0] glyph;
  } cmd_t;

  localparam logic [4:0] FONT [FONT_GLYPHS][7] = '{
    '{5'd14,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17}, '{5'd30,5'd17,5'd17,5'd30,5'd17,5'd17,5'd30},
    '{5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14}, '{5'd30,5'd17,5'd17,5'd17,5'd17,5'd17,5'd30},
    '{5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31}, '{5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16},
    '{5'd14,5'd17,5'd16,5'd23,5'd17,5'd17,5'd15}, '{5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17},
    '{5'd14,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14},      '{5'd7,5'd2,5'd2,5'd2,5'd18,5'd18,5'd12},
    '{5'd17,5'd18,5'd20,5'd24,5'd20,5'd18,5'd17}, '{5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31},
    '{5'd17,5'd27,5'd21,5'd21,5'd17,5'd17,5'd17}, '{5'd17,5'd25,5'd21,5'd19,5'd17,5'd17,5'd17},
    '{5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14}, '{5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16},
    '{5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13}, '{5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17},
    '{5'd15,5'd16,5'd16,5'd14,5'd1,5'd1,5'd30},   '{5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4},
    '{5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14}, '{5'd17,5'd17,5'd17,5'd17,5'd17,5'd10,5'd4},
    '{5'd17,5'd17,5'd17,5'd21,5'd21,5'd27,5'd17}, '{5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17},
    '{5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4},     '{5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31},
    '{5'd14,5'd17,5'd19,5'd21,5'd25,5'd17,5'd14}, '{5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14},
    '{5'd14,5'd17,5'd1,5'd2,5'd4,5'd8,5'd31},     '{5'd30,5'd1,5'd1,5'd14,5'd1,5'd1,5'd30},
    '{5'd2,5'd6,5'd10,5'd18,5'd31,5'd2,5'd2},     '{5'd31,5'd16,5'd16,5'd30,5'd1,5'd1,5'd30},
    '{5'd14,5'd16,5'd16,5'd30,5'd17,5'd17,5'd14}, '{5'd31,5'd1,5'd2,5'd4,5'd8,5'd8,5'd8},
    '{5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14}, '{5'd14,5'd17,5'd17,5'd15,5'd1,5'd1,5'd14}
  };

  function automatic logic [5:0] classify(input logic [7:0] code);
    logic [7:0] c;
    logic [7:0] d;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      return d[5:0];
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return d[5:0] + G_DIGIT0;
    end
    if (c == 8'h2D) return G_DASH;
    if (c == 8'h3A) return G_COLON;
    if (c == 8'h2E) return G_DOT;
    if (c == 8'h2F) return G_SLASH;
    return G_NONE;
  endfunction

  function automatic logic [4:0] glyph_row(input logic [5:0] g, input logic [2:0] y);
    logic [4:0] bits;
    bits = '0;
    if (g < 6'(FONT_GLYPHS)) begin
      bits = FONT[g][y];
    end else if (g == G_DASH) begin
      bits = (y == 3'd3) ? 5'd14 : 5'd0;
    end else if (g == G_COLON) begin
      bits = (y == 3'd2 || y == 3'd5) ? 5'd4 : 5'd0;
    end else if (g == G_DOT) begin
      bits = (y == 3'd6) ? 5'd4 : 5'd0;
    end else if (g == G_SLASH) begin
      bits = 5'd1 << ((y < 3'd5) ? y : 3'd4);
    end
    return bits;
  endfunction

  function automatic logic [9:0] double_mask(input logic [4:0] b);
    return {b[4], b[4], b[3], b[3], b[2], b[2], b[1], b[1], b[0], b[0]};
  endfunction

endpackage

FILE: rtl/tlgr_front.sv
// Front end: accepts text items, keeps the line row and column, and queues draw commands.
// Depends on tlgr_pkg.
module tlgr_front import tlgr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  mode_t      mode,
  input  logic [7:0] char_code,
  input  logic [8:0] new_row,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [8:0] line_row;
  logic [8:0] line_row_next;
  logic [9:0] column;
  logic [9:0] column_next;
  logic [9:0] row_sum;
  logic [8:0] wrap_row;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign row_sum  = {1'b0, line_row} + LINE_HEIGHT;
  assign wrap_row = (line_row > WRAP_ABOVE) ? WRAP_TO : line_row;

  always_comb begin
    line_row_next = line_row;
    column_next   = column;
    push          = 1'b0;
    push_cmd      = '{is_fill: 1'b0, row: line_row, x: column, glyph: classify(char_code)};
    if (accept) begin
      unique case (mode)
        MODE_BEGIN: begin
          line_row_next    = wrap_row;
          column_next      = COL_START;
          push             = 1'b1;
          push_cmd.is_fill = 1'b1;
          push_cmd.row     = wrap_row;
        end
        MODE_CHAR: begin
          if (column < COL_LIMIT) begin
            push        = 1'b1;
            column_next = column + COL_STEP;
          end
        end
        MODE_END: begin
          line_row_next = (row_sum > {1'b0, ROW_MAX}) ? ROW_MAX : row_sum[8:0];
        end
        MODE_SETROW: begin
          line_row_next = new_row;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_row <= '0;
      column   <= COL_START;
    end else begin
      line_row <= line_row_next;
      column   <= column_next;
    end
  end

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    column >= COL_START && column < COL_LIMIT + COL_STEP)
    else $error("column left its reachable range");

endmodule

FILE: rtl/tlgr_queue.sv
// Short command queue between the front end and the row sequencer.
// Depends on tlgr_pkg.
module tlgr_queue import tlgr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t             slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");

endmodule

FILE: rtl/tlgr_back.sv
// Back end: steps through the rows of each queued command and drives the output register.
// Depends on tlgr_pkg.
module tlgr_back import tlgr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        head,
  output logic        pop,
  input  logic [15:0] background_colour,
  input  logic [15:0] text_colour,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [8:0]  line_y,
  output logic [9:0]  x_start,
  output logic [9:0]  span_length,
  output logic [9:0]  pixel_mask,
  output logic [15:0] colour,
  output logic        last
);

  logic [4:0] cnt;
  logic [4:0] end_cnt;
  logic       load;
  logic       at_end;

  assign end_cnt = head.is_fill ? FILL_END : GLYPH_END;
  assign at_end  = (cnt == end_cnt);
  assign load    = !q_empty && (!out_valid || out_ready);
  assign pop     = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cnt       <= at_end ? 5'd0 : cnt + 5'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind   <= head.is_fill;
      line_y <= head.row + {4'd0, cnt};
      last   <= at_end;
      if (head.is_fill) begin
        x_start     <= FILL_X;
        span_length <= FILL_LEN;
        pixel_mask  <= '0;
        colour      <= background_colour;
      end else begin
        x_start     <= head.x;
        span_length <= GLYPH_LEN;
        pixel_mask  <= double_mask(glyph_row(head.glyph, cnt[3:1]));
        colour      <= text_colour;
      end
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cnt))
    else $error("row counter moved while the output was stalled");

endmodule

FILE: rtl/text_line_glyph_rasterizer.sv
// Top level of the text line glyph rasterizer: stream ports, APB registers, and
// the front end, command queue and row sequencer. Depends on tlgr_pkg and its modules.
//
// Input requests arrive on s_tvalid/s_tready; s_tuser carries the mode and
// s_tdata the character byte and new row. Each begin-line request yields 22
// background fill writes, each character within the line yields 14 glyph row writes,
// and end-line, set-row and characters past the line end yield none. Writes
// leave on m_tvalid/m_tready with m_tlast on the final write of a request.
// Each draw command passes through the command queue to the output register. The row
// sequencer emits one write per cycle while the receiver takes them; a two-entry
// command queue lets the front end keep taking requests while the sequencer works,
// and requests with no output never enter the queue. When the receiver stalls, the
// output register holds its write, the sequencer waits, and s_tready falls once the
// queue is full.
// Reset clears the row to 0, the column to 20, the queue and the output valid,
// and loads the colour registers with 0x0864 and 0xFFFF. Registers sit at
// byte 0 (background colour) and byte 4 (text colour) of the APB port.
module text_line_glyph_rasterizer import tlgr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], new_row[16:8], zero pad[23:17]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // line_y, x_start, span_length, pixel_mask, colour, zero pad
  output logic [0:0]  m_tuser,   // kind[0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] background_colour;
  logic [15:0] text_colour;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head;
  logic        kind;
  logic [8:0]  line_y;
  logic [9:0]  x_start;
  logic [9:0]  span_length;
  logic [9:0]  pixel_mask;
  logic [15:0] colour;

  assign pready = 1'b1;
  assign prdata = {16'd0, paddr[2] ? text_colour : background_colour};

  always_ff @(posedge clk) begin
    if (rst) begin
      background_colour <= BG_RESET;
      text_colour       <= TEXT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) text_colour <= pwdata[15:0];
      else          background_colour <= pwdata[15:0];
    end
  end

  tlgr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (mode_t'(s_tuser)),
    .char_code (s_tdata[7:0]),
    .new_row   (s_tdata[16:8]),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tlgr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  tlgr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .head              (head),
    .pop               (pop),
    .background_colour (background_colour),
    .text_colour       (text_colour),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .kind              (kind),
    .line_y            (line_y),
    .x_start           (x_start),
    .span_length       (span_length),
    .pixel_mask        (pixel_mask),
    .colour            (colour),
    .last              (m_tlast)
  );

  assign m_tuser = kind;
  assign m_tdata = {1'b0, colour, pixel_mask, span_length, x_start, line_y};

endmodule

FILE: test/tb_text_line_glyph_rasterizer.sv
// Self-checking testbench for text_line_glyph_rasterizer: drives text requests and APB colour
// writes, predicts every framebuffer write and compares the stream field by field.
// Depends on tlgr_pkg and the rasterizer RTL only.
`timescale 1ns / 1ps

module tb_text_line_glyph_rasterizer;
  import tlgr_pkg::*;

  localparam logic [2:0] REG_BACKGROUND = 3'd0;
  localparam logic [2:0] REG_TEXT       = 3'd4;
  localparam logic       KIND_GLYPH     = 1'b0;
  localparam logic       KIND_FILL      = 1'b1;
  localparam int         HOLD_CYCLES    = 400;

  typedef struct packed {
    logic        kind;
    logic [8:0]  y;
    logic [9:0]  x;
    logic [9:0]  len;
    logic [9:0]  mask;
    logic [15:0] colour;
    logic        last;
  } fb_write_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] code;
    logic [8:0] row;
    logic       typed;
    fb_write_t  first;
  } text_req_t;

  localparam logic [4:0] GLYPH_ROWS [36][7] = '{
    '{14,17,17,31,17,17,17}, '{30,17,17,30,17,17,30}, '{14,17,16,16,16,17,14},
    '{30,17,17,17,17,17,30}, '{31,16,16,30,16,16,31}, '{31,16,16,30,16,16,16},
    '{14,17,16,23,17,17,15}, '{17,17,17,31,17,17,17}, '{14,4,4,4,4,4,14},
    '{7,2,2,2,18,18,12},     '{17,18,20,24,20,18,17}, '{16,16,16,16,16,16,31},
    '{17,27,21,21,17,17,17}, '{17,25,21,19,17,17,17}, '{14,17,17,17,17,17,14},
    '{30,17,17,30,16,16,16}, '{14,17,17,17,21,18,13}, '{30,17,17,30,20,18,17},
    '{15,16,16,14,1,1,30},   '{31,4,4,4,4,4,4},       '{17,17,17,17,17,17,14},
    '{17,17,17,17,17,10,4},  '{17,17,17,21,21,27,17}, '{17,17,10,4,10,17,17},
    '{17,17,10,4,4,4,4},     '{31,1,2,4,8,16,31},     '{14,17,19,21,25,17,14},
    '{4,12,4,4,4,4,14},      '{14,17,1,2,4,8,31},     '{30,1,1,14,1,1,30},
    '{2,6,10,18,31,2,2},     '{31,16,16,30,1,1,30},   '{14,16,16,30,17,17,14},
    '{31,1,2,4,8,8,8},       '{14,17,17,14,17,17,14}, '{14,17,17,15,1,1,14}
  };

  localparam fb_write_t NO_CHECK = '0;

  // Rows with a typed first write are checked against that value instead of the prediction.
  localparam text_req_t DIRECTED [25] = '{
    '{MODE_CHAR,   8'h41, 9'd0,   1'b1,
      {KIND_GLYPH, 9'd0, 10'd20, GLYPH_LEN, 10'h0FC, 16'hFFFF, 1'b0}},
    '{MODE_BEGIN,  8'h00, 9'd0,   1'b1,
      {KIND_FILL, 9'd0, FILL_X, FILL_LEN, 10'd0, BG_RESET, 1'b0}},
    '{MODE_CHAR,   8'h61, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h7A, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h30, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h39, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h2D, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h3A, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h2E, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h2F, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h00, 9'd0,   1'b1,
      {KIND_GLYPH, 9'd0, 10'd116, GLYPH_LEN, 10'd0, 16'hFFFF, 1'b0}},
    '{MODE_CHAR,   8'hFF, 9'd511, 1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h40, 9'd0,   1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h7B, 9'd0,   1'b0, NO_CHECK},
    '{MODE_END,    8'hFF, 9'd511, 1'b0, NO_CHECK},
    '{MODE_SETROW, 8'hFF, 9'd0,   1'b0, NO_CHECK},
    '{MODE_SETROW, 8'h00, 9'd511, 1'b0, NO_CHECK},
    '{MODE_CHAR,   8'h57, 9'd0,   1'b0, NO_CHECK},
    '{MODE_END,    8'h00, 9'd0,   1'b0, NO_CHECK},
    '{MODE_BEGIN,  8'h00, 9'd0,   1'b1,
      {KIND_FILL, 9'd124, FILL_X, FILL_LEN, 10'd0, BG_RESET, 1'b0}},
    '{MODE_SETROW, 8'h00, 9'd444, 1'b0, NO_CHECK},
    '{MODE_BEGIN,  8'h00, 9'd0,   1'b1,
      {KIND_FILL, 9'd444, FILL_X, FILL_LEN, 10'd0, BG_RESET, 1'b0}},
    '{MODE_SETROW, 8'h00, 9'd445, 1'b0, NO_CHECK},
    '{MODE_BEGIN,  8'h00, 9'd0,   1'b1,
      {KIND_FILL, 9'd124, FILL_X, FILL_LEN, 10'd0, BG_RESET, 1'b0}},
    '{MODE_CHAR,   8'h4D, 9'd0,   1'b0, NO_CHECK}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // char_code[7:0], new_row[16:8], zero pad[23:17]
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // line_y, x_start, span_length, pixel_mask, colour, zero pad
  logic [0:0]  m_tuser;        // kind[0]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fb_write_t   pending_writes[$];
  logic [8:0]  cur_row = '0;
  logic [9:0]  pen_col = COL_START;
  logic [15:0] fill_colour = BG_RESET;
  logic [15:0] ink_colour = TEXT_RESET;
  int          mismatches = 0;
  int          burst_left = 0;
  bit          hold_request = 1'b0;

  text_line_glyph_rasterizer u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_text_line_glyph_rasterizer: errors");
    $finish;
  end

  function automatic logic [4:0] font_bits(input logic [7:0] code, input int y);
    logic [7:0] c;
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    if (c >= "A" && c <= "Z") return GLYPH_ROWS[c - "A"][y];
    if (c >= "0" && c <= "9") return GLYPH_ROWS[c - "0" + 26][y];
    if (c == "-") return (y == 3) ? 5'd14 : 5'd0;
    if (c == ":") return (y == 2 || y == 5) ? 5'd4 : 5'd0;
    if (c == ".") return (y == 6) ? 5'd4 : 5'd0;
    if (c == "/") return 5'd1 << ((y < 5) ? y : 4);
    return 5'd0;
  endfunction

  function automatic logic [9:0] widen_bits(input logic [4:0] bits);
    logic [9:0] m;
    for (int k = 0; k < 5; k++) begin
      m[2*k]   = bits[k];
      m[2*k+1] = bits[k];
    end
    return m;
  endfunction

  // Updates the line state and queues every framebuffer write the request causes.
  task automatic rasterize_request(input mode_t mode, input logic [7:0] code,
                                   input logic [8:0] row, output int n);
    fb_write_t w;
    int        below;
    n = 0;
    case (mode)
      MODE_BEGIN: begin
        if (cur_row > WRAP_ABOVE) cur_row = WRAP_TO;
        pen_col = COL_START;
        for (int i = 0; i < 22; i++) begin
          w.kind   = KIND_FILL;
          w.y      = cur_row + i[8:0];
          w.x      = FILL_X;
          w.len    = FILL_LEN;
          w.mask   = '0;
          w.colour = fill_colour;
          w.last   = (i == 21);
          pending_writes.push_back(w);
          n++;
        end
      end
      MODE_CHAR: begin
        if (pen_col < COL_LIMIT) begin
          for (int i = 0; i < 14; i++) begin
            w.kind   = KIND_GLYPH;
            w.y      = cur_row + i[8:0];
            w.x      = pen_col;
            w.len    = GLYPH_LEN;
            w.mask   = widen_bits(font_bits(code, i / 2));
            w.colour = ink_colour;
            w.last   = (i == 13);
            pending_writes.push_back(w);
            n++;
          end
          pen_col = pen_col + COL_STEP;
        end
      end
      MODE_END: begin
        below = int'(cur_row) + 22;
        cur_row = (below > 511) ? ROW_MAX : below[8:0];
      end
      default: begin
        cur_row = row;
      end
    endcase
  endtask

  // Called at a rising edge; returns at the edge where the request is accepted.
  task automatic send_request(input mode_t mode, input logic [7:0] code, input logic [8:0] row,
                              input logic typed, input fb_write_t first);
    int gap;
    int n;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, row, code};
    do @(posedge clk); while (!s_tready);
    rasterize_request(mode, code, row, n);
    if (typed && n > 0) pending_writes[pending_writes.size() - n] = first;
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_BACKGROUND) fill_colour = value;
    else if (addr == REG_TEXT) ink_colour = value;
  endtask

  // Stops sending and waits until every predicted write has arrived, then idles before returning.
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h41, 8'h5A));
      1: return 8'($urandom_range(8'h61, 8'h7A));
      2: return 8'($urandom_range(8'h2D, 8'h3A));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly whole lines of random text, with stray requests of any mode mixed in.
  task automatic run_text(input int target, input bit long_line);
    int sent;
    int count;
    int pick;
    sent = 0;
    if (long_line) begin
      send_request(MODE_BEGIN, 8'($urandom), 9'($urandom), 1'b0, NO_CHECK);
      repeat (53) send_request(MODE_CHAR, random_char(), 9'($urandom), 1'b0, NO_CHECK);
      send_request(MODE_END, 8'($urandom), 9'($urandom), 1'b0, NO_CHECK);
      sent = 55;
    end
    while (sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if (pick == 6) begin
          send_request(MODE_SETROW, 8'($urandom), 9'($urandom_range(0, 511)), 1'b0, NO_CHECK);
          sent++;
        end
        send_request(MODE_BEGIN, 8'($urandom), 9'($urandom), 1'b0, NO_CHECK);
        count = $urandom_range(1, 8);
        repeat (count) send_request(MODE_CHAR, random_char(), 9'($urandom), 1'b0, NO_CHECK);
        send_request(MODE_END, 8'($urandom), 9'($urandom), 1'b0, NO_CHECK);
        sent += count + 2;
      end else begin
        send_request(mode_t'($urandom_range(0, 3)), 8'($urandom), 9'($urandom), 1'b0, NO_CHECK);
        sent++;
      end
    end
  endtask

  task automatic report_write(input string what, input fb_write_t want, input fb_write_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want kind %0d y %0d x %0d len %0d mask %h colour %h last %0d", what,
               want.kind, want.y, want.x, want.len, want.mask, want.colour, want.last);
      $display("  got kind %0d y %0d x %0d len %0d mask %h colour %h last %0d",
               got.kind, got.y, got.x, got.len, got.mask, got.colour, got.last);
    end
  endtask

  always @(posedge clk) begin
    fb_write_t got;
    fb_write_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind   = m_tuser[0];
      got.y      = m_tdata[8:0];
      got.x      = m_tdata[18:9];
      got.len    = m_tdata[28:19];
      got.mask   = m_tdata[38:29];
      got.colour = m_tdata[54:39];
      got.last   = m_tlast;
      if (pending_writes.size() == 0) begin
        report_write("unexpected write", NO_CHECK, got);
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) report_write("write mismatch", want, got);
      end
    end
  end

  // The receiver switches between steady, light and heavy stalling in spans of random length.
  initial begin
    int span;
    int style;
    forever begin
      span  = $urandom_range(1, 40);
      style = $urandom_range(0, 2);
      repeat (span) begin
        @(posedge clk);
        if (hold_request) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
        end
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].mode, DIRECTED[i].code, DIRECTED[i].row,
                   DIRECTED[i].typed, DIRECTED[i].first);
    end
    settle();
    write_reg(REG_BACKGROUND, 16'h0000);
    write_reg(REG_TEXT, 16'h0000);
    run_text(60, 1'b1);
    settle();
    write_reg(REG_BACKGROUND, 16'hFFFF);
    write_reg(REG_TEXT, 16'hFFFF);
    hold_request = 1'b1;
    run_text(20, 1'b0);
    settle();
    write_reg(REG_BACKGROUND, 16'($urandom));
    write_reg(REG_TEXT, 16'($urandom));
    run_text(20, 1'b0);
    settle();
    write_reg(REG_BACKGROUND, 16'($urandom));
    write_reg(REG_TEXT, 16'($urandom));
    run_text(20, 1'b0);
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_text_line_glyph_rasterizer: clean");
    end else begin
      $display("tb_text_line_glyph_rasterizer: errors");
    end
    $finish;
  end

endmodule
